### src/spts_pkg.sv
// ----------------------------------------------------------------------------
// spts_pkg
// Shared types and codes for the sparse polynomial term store: request
// opcodes, status codes, the sequencer state type and the control bundle
// driven into the multiply-add unit.
// ----------------------------------------------------------------------------
package spts_pkg;

    // Field widths fixed by the request and result formats.
    localparam int OP_W     = 2;
    localparam int DEG_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 6;

    // Request opcodes. Code 3 is unused and changes nothing.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MACL,
        S_POST
    } t_state;

    // Control bundle for the multiply-add unit.
    typedef struct packed {
        logic clear;
        logic step;
    } t_mac_ctrl;

endpackage

### src/spts_coef_ram.sv
// ----------------------------------------------------------------------------
// spts_coef_ram
// Coefficient memory with one write port and one registered read port.
// Coefficients are stored at their cut width and sign-extended on read.
// ----------------------------------------------------------------------------
module spts_coef_ram
    import spts_pkg::*;
#(
    parameter int SLOTS = 32,
    parameter int IDX_W = 5,
    parameter int SW    = 32
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [IDX_W-1:0]          i_wr_addr,
    input  logic [SW-1:0]             i_wr_data,
    input  logic                      i_rd_en,
    input  logic [IDX_W-1:0]          i_rd_addr,
    output logic signed [VALUE_W-1:0] o_rd_data
);

    logic [SW-1:0]        r_mem [SLOTS];
    logic signed [SW-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Sign-extend the stored coefficient to the accumulator width.
    assign o_rd_data = VALUE_W'(r_rd_data);

endmodule

### src/spts_mac.sv
// ----------------------------------------------------------------------------
// spts_mac
// Shared Horner multiply-add unit. Each step replaces the accumulator with
// accumulator * point + coefficient, wrapped to 32 bits.
// ----------------------------------------------------------------------------
module spts_mac
    import spts_pkg::*;
(
    input  logic               i_clk,
    input  t_mac_ctrl          i_ctrl,
    input  logic [VALUE_W-1:0] i_point,
    input  logic [VALUE_W-1:0] i_coef,
    output logic [VALUE_W-1:0] o_acc
);

    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;

    // One Horner step; only the low 32 bits of the product are kept.
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.step) begin
            n_acc = r_acc * i_point + i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

### src/sparse_polynomial_term_store.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_store
// Sparse integer polynomial held as one coefficient per degree with a present
// flag. Requests insert a term, delete a term or evaluate the polynomial at a
// point by Horner's rule from the highest degree down, wrapped to 32 bits.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         i_in_valid / o_in_ready   i_op, i_degree,
//                                                  i_coefficient, i_point
//   result    out        o_out_valid / i_out_ready o_status, o_value,
//                                                  o_term_total
//
// Insert, delete, the unused opcode and an evaluate of an empty store finish
// in the cycle they are accepted. Any other evaluate holds off further requests
// while the single multiply-add unit walks one degree slot per cycle behind
// the registered coefficient read, through S_EVAL, S_MACL and S_POST.
// Reset clears the present flags and the term count at once; no sweep.
// A result waiting in the output register blocks the next request only if it
// is not being taken in the same cycle.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_store
    import spts_pkg::*;
#(
    parameter int DEGREES    = 32,
    parameter int COEF_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [DEG_W-1:0]    i_degree,
    input  logic [VALUE_W-1:0]  i_coefficient,
    input  logic [VALUE_W-1:0]  i_point,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_value,
    output logic [TOTAL_W-1:0]  o_term_total
);

    // Only degrees that the request field can name get a slot; the store holds
    // at most that many, and degrees beyond the last slot are refused.
    localparam int MAX_DEG = 1 << DEG_W;
    localparam int SLOTS   = (DEGREES < MAX_DEG) ? DEGREES : MAX_DEG;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int SW      = (COEF_WIDTH < VALUE_W) ? COEF_WIDTH : VALUE_W;

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_present, n_present;
    logic [TOTAL_W-1:0] r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_tap_vld, n_tap_vld;
    logic               r_tap_on;
    logic [VALUE_W-1:0] r_point, n_point;
    logic               r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic               out_free;
    logic               in_acc;
    logic               in_range;
    logic [IDX_W-1:0]   deg_idx;
    logic               ram_wr;
    logic               ram_rd;
    logic signed [VALUE_W-1:0] ram_data;
    logic [VALUE_W-1:0] mac_coef;
    logic [VALUE_W-1:0] acc;
    t_mac_ctrl          mac_ctrl;

    // Handshake and request decode.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, i_degree} < TOTAL_W'(SLOTS);
    assign deg_idx    = i_degree[IDX_W-1:0];

    // Absent slots contribute a zero coefficient.
    assign mac_coef = r_tap_on ? ram_data : '0;

    // Sequencer: next state, store updates and result loading.
    always_comb begin
        logic post;
        post        = 1'b0;
        n_state     = r_state;
        n_present   = r_present;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tap_vld   = 1'b0;
        n_point     = r_point;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_value     = r_value;
        n_total     = r_total;
        ram_wr      = 1'b0;
        ram_rd      = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.step  = r_tap_vld;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    post     = 1'b1;
                    n_status = ST_OK;
                    n_value  = '0;
                    case (i_op)
                        OP_INSERT: begin
                            if (!in_range) begin
                                n_status = ST_MISSING;
                            end else if (r_present[deg_idx]) begin
                                n_status = ST_DUP;
                            end else begin
                                n_present[deg_idx] = 1'b1;
                                n_count = r_count + TOTAL_W'(1);
                                ram_wr  = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (!in_range || !r_present[deg_idx]) begin
                                n_status = ST_MISSING;
                            end else begin
                                n_present[deg_idx] = 1'b0;
                                n_count = r_count - TOTAL_W'(1);
                            end
                        end
                        OP_EVAL: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                post           = 1'b0;
                                n_point        = i_point;
                                n_idx          = IDX_W'(SLOTS - 1);
                                mac_ctrl.clear = 1'b1;
                                n_state        = S_EVAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (post) begin
                        n_out_valid = 1'b1;
                        n_total     = n_count;
                    end
                end
            end
            S_EVAL: begin
                // Read one slot a cycle, highest degree first.
                ram_rd    = 1'b1;
                n_tap_vld = 1'b1;
                if (r_idx == '0) begin
                    n_state = S_MACL;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            S_MACL: begin
                // The last slot's multiply-add completes here.
                n_state = S_POST;
            end
            S_POST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_value     = acc;
                    n_total     = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_count     <= '0;
            r_tap_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_count     <= n_count;
            r_tap_vld   <= n_tap_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_point  <= n_point;
        r_status <= n_status;
        r_value  <= n_value;
        r_total  <= n_total;
        if (ram_rd) begin
            r_tap_on <= r_present[r_idx];
        end
    end

    spts_coef_ram #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .SW    (SW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (deg_idx),
        .i_wr_data (i_coefficient[SW-1:0]),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_data)
    );

    spts_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_point (r_point),
        .i_coef  (mac_coef),
        .o_acc   (acc)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_value      = r_value;
    assign o_term_total = r_total;

    // The term count always matches the number of present flags.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == TOTAL_W'($countones(r_present)))
        else $error("term count differs from present flags");

    // Multiply-add steps happen only during an evaluation walk.
    a_step_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap_vld |-> (r_state == S_EVAL || r_state == S_MACL))
        else $error("multiply-add step outside evaluation");

    // An evaluate on a non-empty store starts the walk.
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_op == OP_EVAL && r_count != '0) |=> r_state == S_EVAL)
        else $error("evaluate did not start the walk");

    // The store never changes while an evaluation is in progress.
    a_store_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL || r_state == S_MACL) |=> $stable(r_present))
        else $error("present flags changed during evaluation");

endmodule
